[hw/rtl/rsa_pkg.sv]
package rsa_pkg;

  localparam int DEVICE_ENTRIES_DEF = 32;
  localparam int KIND_ENTRIES_DEF   = 16;

  // operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // entry type codes
  localparam logic [1:0] ET_DEVICE  = 2'd0;
  localparam logic [1:0] ET_KIND    = 2'd1;
  localparam logic [1:0] ET_SUMMARY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HDR_COUNT = 2'd0;
  localparam logic [1:0] CFG_HDR_FIRST = 2'd1;
  localparam logic [1:0] CFG_HDR_LAST  = 2'd2;

  // warning bit positions
  localparam int W_ORDER      = 0;
  localparam int W_HDR_COUNT  = 1;
  localparam int W_HDR_FIRST  = 2;
  localparam int W_HDR_LAST   = 3;
  localparam int W_SUM_KIND   = 4;
  localparam int W_SUM_TOTAL  = 5;
  localparam int W_EMPTY      = 6;
  localparam int W_ZERO_CNT   = 7;
  localparam int W_INV_RANGE  = 8;
  localparam int W_DEV_OVF    = 9;
  localparam int W_KIND_OVF   = 10;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] PAY_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        operation;
    logic [15:0] device_id;
    logic [7:0]  packet_kind;
    logic [63:0] capture_time;
    logic [15:0] payload_len;
  } rsa_in_t;

  typedef struct packed {
    logic [1:0]  entry_type;
    logic [15:0] entry_key;
    logic [31:0] record_total;
    logic [63:0] first_time;
    logic [63:0] last_time;
    logic [47:0] payload_total;
    logic [10:0] warnings;
    logic        last_of_run;
  } rsa_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] cnt;
    logic [63:0] first;
    logic [63:0] last;
    logic [47:0] pay;
  } rsa_dev_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] cnt;
  } rsa_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_KSCAN,
    ST_DSUM,
    ST_KSUM,
    ST_DSEL,
    ST_KSEL,
    ST_SUM
  } rsa_state_e;

endpackage

[hw/rtl/rsa_stream_if.sv]
interface rsa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rsa_store.sv]
module rsa_store #(
  parameter int DEVICE_ENTRIES = rsa_pkg::DEVICE_ENTRIES_DEF,
  parameter int KIND_ENTRIES   = rsa_pkg::KIND_ENTRIES_DEF,
  localparam int DAW = (DEVICE_ENTRIES > 1) ? $clog2(DEVICE_ENTRIES) : 1,
  localparam int KAW = (KIND_ENTRIES > 1) ? $clog2(KIND_ENTRIES) : 1
) (
  input  logic               clk_i,
  input  logic               dev_we_i,
  input  logic [DAW-1:0]     dev_waddr_i,
  input  rsa_pkg::rsa_dev_t  dev_wdata_i,
  input  logic [DAW-1:0]     dev_raddr_i,
  output rsa_pkg::rsa_dev_t  dev_rdata_o,
  input  logic               kind_we_i,
  input  logic [KAW-1:0]     kind_waddr_i,
  input  rsa_pkg::rsa_kind_t kind_wdata_i,
  input  logic [KAW-1:0]     kind_raddr_i,
  output rsa_pkg::rsa_kind_t kind_rdata_o
);

  rsa_pkg::rsa_dev_t  dev_mem  [DEVICE_ENTRIES];
  rsa_pkg::rsa_kind_t kind_mem [KIND_ENTRIES];
  rsa_pkg::rsa_dev_t  dev_rdata_q;
  rsa_pkg::rsa_kind_t kind_rdata_q;

  always_ff @(posedge clk_i) begin
    if (dev_we_i) begin
      dev_mem[dev_waddr_i] <= dev_wdata_i;
    end
    dev_rdata_q <= dev_mem[dev_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (kind_we_i) begin
      kind_mem[kind_waddr_i] <= kind_wdata_i;
    end
    kind_rdata_q <= kind_mem[kind_raddr_i];
  end

  assign dev_rdata_o  = dev_rdata_q;
  assign kind_rdata_o = kind_rdata_q;

endmodule

[hw/rtl/record_stats_aggregator_core.sv]
// channel   | dir | payload              | handshake
// item_i    | in  | rsa_pkg::rsa_in_t    | valid / ready, taken when both high
// result_o  | out | rsa_pkg::rsa_out_t   | valid / ready, taken when both high
// cfg       | in  | cfg_idx_i/cfg_data_i | written when cfg_we_i high
//
// a record item: accept, then a key scan of each table through its one read port,
// entry by entry, then an update, a new entry or an overflow flag
// end of archive: a sum pass over both tables, then one selection scan per
// emitted entry and the summary, plus any result_o stalls
// item_i is ready only in idle; the output register lets result_o stall freely
// reset clears the fill counts and all control state, no clearing pass needed
module record_stats_aggregator_core #(
  parameter int DEVICE_ENTRIES = rsa_pkg::DEVICE_ENTRIES_DEF,
  parameter int KIND_ENTRIES   = rsa_pkg::KIND_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rsa_stream_if.sink          item_i,
  rsa_stream_if.source        result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int DAW  = (DEVICE_ENTRIES > 1) ? $clog2(DEVICE_ENTRIES) : 1;
  localparam int KAW  = (KIND_ENTRIES > 1) ? $clog2(KIND_ENTRIES) : 1;
  localparam int DCW  = $clog2(DEVICE_ENTRIES + 1);
  localparam int KCW  = $clog2(KIND_ENTRIES + 1);
  localparam int SCW  = (DCW > KCW) ? DCW : KCW;
  localparam int SUMW = 32 + SCW;

  // higher count first, then lower key
  function automatic logic goes_before(logic [31:0] ca, logic [15:0] ka,
                                       logic [31:0] cb, logic [15:0] kb);
    logic res;
    if (ca != cb) begin
      res = ca > cb;
    end else begin
      res = ka < kb;
    end
    return res;
  endfunction

  // header registers
  logic [31:0] hdr_cnt_q;
  logic [63:0] hdr_first_q, hdr_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      hdr_first_q <= '0;
      hdr_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsa_pkg::CFG_HDR_COUNT: hdr_cnt_q   <= cfg_data_i[31:0];
        rsa_pkg::CFG_HDR_FIRST: hdr_first_q <= cfg_data_i;
        rsa_pkg::CFG_HDR_LAST:  hdr_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsa_pkg::rsa_state_e state_q, state_d;
  rsa_pkg::rsa_in_t    rec_q, rec_d;
  logic [DCW-1:0]      dev_fill_q, dev_fill_d;
  logic [KCW-1:0]      kind_fill_q, kind_fill_d;
  logic [31:0]         obs_total_q, obs_total_d;
  logic [63:0]         obs_first_q, obs_first_d;
  logic [63:0]         obs_last_q, obs_last_d;
  logic [63:0]         prev_q, prev_d;
  logic                unordered_q, unordered_d;
  logic                dev_ovf_q, dev_ovf_d;
  logic                kind_ovf_q, kind_ovf_d;
  logic [SCW-1:0]      scan_q, scan_d;
  logic [SCW-1:0]      ridx_q, ridx_d;
  logic                rv_q, rv_d;
  logic [SUMW-1:0]     dsum_q, dsum_d, ksum_q, ksum_d;
  logic                zero_cnt_q, zero_cnt_d;
  logic                inv_q, inv_d;
  logic                best_valid_q, best_valid_d;
  rsa_pkg::rsa_dev_t   best_dev_q, best_dev_d;
  rsa_pkg::rsa_kind_t  best_kind_q, best_kind_d;
  logic [SCW-1:0]      best_idx_q, best_idx_d;
  logic [DEVICE_ENTRIES-1:0] dev_done_q, dev_done_d;
  logic [KIND_ENTRIES-1:0]   kind_done_q, kind_done_d;
  rsa_pkg::rsa_out_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // table memories
  logic               dev_we, kind_we;
  logic [DAW-1:0]     dev_waddr;
  logic [KAW-1:0]     kind_waddr;
  rsa_pkg::rsa_dev_t  dev_wdata, dev_rd;
  rsa_pkg::rsa_kind_t kind_wdata, kind_rd;

  rsa_store #(
    .DEVICE_ENTRIES(DEVICE_ENTRIES),
    .KIND_ENTRIES  (KIND_ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .dev_we_i    (dev_we),
    .dev_waddr_i (dev_waddr),
    .dev_wdata_i (dev_wdata),
    .dev_raddr_i (scan_q[DAW-1:0]),
    .dev_rdata_o (dev_rd),
    .kind_we_i   (kind_we),
    .kind_waddr_i(kind_waddr),
    .kind_wdata_i(kind_wdata),
    .kind_raddr_i(scan_q[KAW-1:0]),
    .kind_rdata_o(kind_rd)
  );

  logic        can_load;
  logic        dev_hit, kind_hit;
  logic        dev_more, kind_more;
  logic [48:0] pay_sum;
  logic [10:0] warn;
  logic [63:0] t_in;

  assign can_load  = !out_valid_q || result_o.ready;
  assign dev_hit   = rv_q && (dev_rd.id == rec_q.device_id);
  assign kind_hit  = rv_q && (kind_rd.id == rec_q.packet_kind);
  assign dev_more  = scan_q < SCW'(dev_fill_q);
  assign kind_more = scan_q < SCW'(kind_fill_q);
  assign pay_sum   = {1'b0, dev_rd.pay} + 49'(rec_q.payload_len);
  assign t_in      = item_i.data.capture_time;

  always_comb begin
    warn = '0;
    warn[rsa_pkg::W_ORDER]     = unordered_q;
    warn[rsa_pkg::W_HDR_COUNT] = obs_total_q != hdr_cnt_q;
    warn[rsa_pkg::W_HDR_FIRST] = (obs_total_q != '0) && (hdr_first_q != obs_first_q);
    warn[rsa_pkg::W_HDR_LAST]  = (obs_total_q != '0) && (hdr_last_q != obs_last_q);
    warn[rsa_pkg::W_SUM_KIND]  = dsum_q != ksum_q;
    warn[rsa_pkg::W_SUM_TOTAL] = (obs_total_q != '0) && (dsum_q != SUMW'(obs_total_q));
    warn[rsa_pkg::W_EMPTY]     = (obs_total_q == '0) &&
                                 ((dev_fill_q != '0) || (kind_fill_q != '0));
    warn[rsa_pkg::W_ZERO_CNT]  = zero_cnt_q;
    warn[rsa_pkg::W_INV_RANGE] = inv_q;
    warn[rsa_pkg::W_DEV_OVF]   = dev_ovf_q;
    warn[rsa_pkg::W_KIND_OVF]  = kind_ovf_q;
  end

  always_comb begin
    state_d      = state_q;
    rec_d        = rec_q;
    dev_fill_d   = dev_fill_q;
    kind_fill_d  = kind_fill_q;
    obs_total_d  = obs_total_q;
    obs_first_d  = obs_first_q;
    obs_last_d   = obs_last_q;
    prev_d       = prev_q;
    unordered_d  = unordered_q;
    dev_ovf_d    = dev_ovf_q;
    kind_ovf_d   = kind_ovf_q;
    scan_d       = scan_q;
    ridx_d       = scan_q;
    rv_d         = 1'b0;
    dsum_d       = dsum_q;
    ksum_d       = ksum_q;
    zero_cnt_d   = zero_cnt_q;
    inv_d        = inv_q;
    best_valid_d = best_valid_q;
    best_dev_d   = best_dev_q;
    best_kind_d  = best_kind_q;
    best_idx_d   = best_idx_q;
    dev_done_d   = dev_done_q;
    kind_done_d  = kind_done_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    dev_we       = 1'b0;
    dev_waddr    = dev_fill_q[DAW-1:0];
    dev_wdata    = '0;
    kind_we      = 1'b0;
    kind_waddr   = kind_fill_q[KAW-1:0];
    kind_wdata   = '0;
    item_i.ready = state_q == rsa_pkg::ST_IDLE;

    case (state_q)
      rsa_pkg::ST_IDLE: begin
        if (item_i.valid) begin
          rec_d  = item_i.data;
          scan_d = '0;
          if (item_i.data.operation == rsa_pkg::OP_FINISH) begin
            state_d    = rsa_pkg::ST_DSUM;
            dsum_d     = '0;
            ksum_d     = '0;
            zero_cnt_d = 1'b0;
            inv_d      = 1'b0;
          end else begin
            state_d = rsa_pkg::ST_DSCAN;
            // global statistics
            if (obs_total_q == '0) begin
              obs_first_d = t_in;
              obs_last_d  = t_in;
            end else begin
              if (t_in < prev_q) unordered_d = 1'b1;
              if (t_in < obs_first_q) obs_first_d = t_in;
              if (t_in > obs_last_q) obs_last_d = t_in;
            end
            prev_d = t_in;
            if (obs_total_q != rsa_pkg::CNT_MAX) obs_total_d = obs_total_q + 32'd1;
          end
        end
      end

      rsa_pkg::ST_DSCAN: begin
        if (dev_hit) begin
          // update the matching entry
          dev_we          = 1'b1;
          dev_waddr       = ridx_q[DAW-1:0];
          dev_wdata       = dev_rd;
          dev_wdata.cnt   = (dev_rd.cnt == rsa_pkg::CNT_MAX) ? dev_rd.cnt
                                                              : dev_rd.cnt + 32'd1;
          dev_wdata.first = (rec_q.capture_time < dev_rd.first) ? rec_q.capture_time
                                                                : dev_rd.first;
          dev_wdata.last  = (rec_q.capture_time > dev_rd.last) ? rec_q.capture_time
                                                               : dev_rd.last;
          dev_wdata.pay   = pay_sum[48] ? rsa_pkg::PAY_MAX : pay_sum[47:0];
          state_d         = rsa_pkg::ST_KSCAN;
          scan_d          = '0;
        end else if (dev_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          // no match: new entry or overflow
          if (dev_fill_q < DCW'(DEVICE_ENTRIES)) begin
            dev_we          = 1'b1;
            dev_wdata.id    = rec_q.device_id;
            dev_wdata.cnt   = 32'd1;
            dev_wdata.first = rec_q.capture_time;
            dev_wdata.last  = rec_q.capture_time;
            dev_wdata.pay   = 48'(rec_q.payload_len);
            dev_fill_d      = dev_fill_q + DCW'(1);
          end else begin
            dev_ovf_d = 1'b1;
          end
          state_d = rsa_pkg::ST_KSCAN;
          scan_d  = '0;
        end
      end

      rsa_pkg::ST_KSCAN: begin
        if (kind_hit) begin
          kind_we        = 1'b1;
          kind_waddr     = ridx_q[KAW-1:0];
          kind_wdata.id  = kind_rd.id;
          kind_wdata.cnt = (kind_rd.cnt == rsa_pkg::CNT_MAX) ? kind_rd.cnt
                                                             : kind_rd.cnt + 32'd1;
          state_d        = rsa_pkg::ST_IDLE;
        end else if (kind_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          if (kind_fill_q < KCW'(KIND_ENTRIES)) begin
            kind_we        = 1'b1;
            kind_wdata.id  = rec_q.packet_kind;
            kind_wdata.cnt = 32'd1;
            kind_fill_d    = kind_fill_q + KCW'(1);
          end else begin
            kind_ovf_d = 1'b1;
          end
          state_d = rsa_pkg::ST_IDLE;
        end
      end

      rsa_pkg::ST_DSUM: begin
        if (rv_q) begin
          dsum_d = dsum_q + SUMW'(dev_rd.cnt);
          if (dev_rd.cnt == '0) zero_cnt_d = 1'b1;
          if (dev_rd.first > dev_rd.last) inv_d = 1'b1;
        end
        if (dev_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          state_d = rsa_pkg::ST_KSUM;
          scan_d  = '0;
        end
      end

      rsa_pkg::ST_KSUM: begin
        if (rv_q) begin
          ksum_d = ksum_q + SUMW'(kind_rd.cnt);
        end
        if (kind_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          state_d      = rsa_pkg::ST_DSEL;
          scan_d       = '0;
          best_valid_d = 1'b0;
        end
      end

      rsa_pkg::ST_DSEL: begin
        // selection pass: best entry not yet emitted
        if (rv_q && !dev_done_q[ridx_q[DAW-1:0]] &&
            (!best_valid_q ||
             goes_before(dev_rd.cnt, dev_rd.id, best_dev_q.cnt, best_dev_q.id))) begin
          best_valid_d = 1'b1;
          best_dev_d   = dev_rd;
          best_idx_d   = ridx_q;
        end
        if (dev_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          if (best_valid_q) begin
            if (can_load) begin
              out_valid_d         = 1'b1;
              out_d               = '0;
              out_d.entry_type    = rsa_pkg::ET_DEVICE;
              out_d.entry_key     = best_dev_q.id;
              out_d.record_total  = best_dev_q.cnt;
              out_d.first_time    = best_dev_q.first;
              out_d.last_time     = best_dev_q.last;
              out_d.payload_total = best_dev_q.pay;
              dev_done_d[best_idx_q[DAW-1:0]] = 1'b1;
              best_valid_d        = 1'b0;
              scan_d              = '0;
            end
          end else begin
            state_d = rsa_pkg::ST_KSEL;
            scan_d  = '0;
          end
        end
      end

      rsa_pkg::ST_KSEL: begin
        if (rv_q && !kind_done_q[ridx_q[KAW-1:0]] &&
            (!best_valid_q ||
             goes_before(kind_rd.cnt, 16'(kind_rd.id),
                         best_kind_q.cnt, 16'(best_kind_q.id)))) begin
          best_valid_d = 1'b1;
          best_kind_d  = kind_rd;
          best_idx_d   = ridx_q;
        end
        if (kind_more) begin
          rv_d   = 1'b1;
          scan_d = scan_q + SCW'(1);
        end else if (!rv_q) begin
          if (best_valid_q) begin
            if (can_load) begin
              out_valid_d        = 1'b1;
              out_d              = '0;
              out_d.entry_type   = rsa_pkg::ET_KIND;
              out_d.entry_key    = 16'(best_kind_q.id);
              out_d.record_total = best_kind_q.cnt;
              kind_done_d[best_idx_q[KAW-1:0]] = 1'b1;
              best_valid_d       = 1'b0;
              scan_d             = '0;
            end
          end else begin
            state_d = rsa_pkg::ST_SUM;
          end
        end
      end

      rsa_pkg::ST_SUM: begin
        if (can_load) begin
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.entry_type   = rsa_pkg::ET_SUMMARY;
          out_d.record_total = obs_total_q;
          out_d.first_time   = obs_first_q;
          out_d.last_time    = obs_last_q;
          out_d.warnings     = warn;
          out_d.last_of_run  = 1'b1;
          // clear the run
          dev_fill_d  = '0;
          kind_fill_d = '0;
          obs_total_d = '0;
          obs_first_d = '0;
          obs_last_d  = '0;
          prev_d      = '0;
          unordered_d = 1'b0;
          dev_ovf_d   = 1'b0;
          kind_ovf_d  = 1'b0;
          dev_done_d  = '0;
          kind_done_d = '0;
          state_d     = rsa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_fill_q   <= '0;
      kind_fill_q  <= '0;
      obs_total_q  <= '0;
      obs_first_q  <= '0;
      obs_last_q   <= '0;
      prev_q       <= '0;
      unordered_q  <= 1'b0;
      dev_ovf_q    <= 1'b0;
      kind_ovf_q   <= 1'b0;
      scan_q       <= '0;
      ridx_q       <= '0;
      rv_q         <= 1'b0;
      dsum_q       <= '0;
      ksum_q       <= '0;
      zero_cnt_q   <= 1'b0;
      inv_q        <= 1'b0;
      best_valid_q <= 1'b0;
      best_idx_q   <= '0;
      dev_done_q   <= '0;
      kind_done_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      dev_fill_q   <= dev_fill_d;
      kind_fill_q  <= kind_fill_d;
      obs_total_q  <= obs_total_d;
      obs_first_q  <= obs_first_d;
      obs_last_q   <= obs_last_d;
      prev_q       <= prev_d;
      unordered_q  <= unordered_d;
      dev_ovf_q    <= dev_ovf_d;
      kind_ovf_q   <= kind_ovf_d;
      scan_q       <= scan_d;
      ridx_q       <= ridx_d;
      rv_q         <= rv_d;
      dsum_q       <= dsum_d;
      ksum_q       <= ksum_d;
      zero_cnt_q   <= zero_cnt_d;
      inv_q        <= inv_d;
      best_valid_q <= best_valid_d;
      best_idx_q   <= best_idx_d;
      dev_done_q   <= dev_done_d;
      kind_done_q  <= kind_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rec_q       <= rec_d;
    best_dev_q  <= best_dev_d;
    best_kind_q <= best_kind_d;
    out_q       <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // fill counts stay within the tables
  a_dev_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dev_fill_q <= DCW'(DEVICE_ENTRIES))
    else $error("device fill count beyond table size");

  a_kind_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_fill_q <= KCW'(KIND_ENTRIES))
    else $error("kind fill count beyond table size");

  // end of archive starts the sum pass
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsa_pkg::ST_IDLE && item_i.valid &&
     item_i.data.operation == rsa_pkg::OP_FINISH) |=> state_q == rsa_pkg::ST_DSUM)
    else $error("end of archive did not start the sum pass");

  // summary load clears the run and presents the item
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsa_pkg::ST_SUM && can_load) |=>
      (dev_fill_q == '0 && kind_fill_q == '0 && obs_total_q == '0 && out_valid_q))
    else $error("summary did not clear the run");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int NDEV  = rsa_pkg::DEVICE_ENTRIES_DEF;
  localparam int NKIND = rsa_pkg::KIND_ENTRIES_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = rsa_pkg::CFG_HDR_COUNT;
  logic [63:0] cfg_data_i = '0;

  rsa_stream_if #(.T(rsa_pkg::rsa_in_t))  item_ch ();
  rsa_stream_if #(.T(rsa_pkg::rsa_out_t)) result_ch ();

  record_stats_aggregator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch.sink),
    .result_o   (result_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  // header registers as the block should hold them
  logic [31:0] hdr_count;
  logic [63:0] hdr_first, hdr_last;

  // mirror of the tables, packed in creation order like the block's slots
  rsa_pkg::rsa_dev_t  dev_tab[NDEV];
  int                 dev_used;
  rsa_pkg::rsa_kind_t kind_tab[NKIND];
  int                 kind_used;
  logic [31:0] seen_total;
  logic [63:0] seen_first, seen_last, prev_time;
  logic        flag_order, flag_dev_ovf, flag_kind_ovf;

  rsa_pkg::rsa_out_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic logic [31:0] sat_add1(logic [31:0] v);
    return (v == rsa_pkg::CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic void clear_stats();
    dev_used = 0;
    kind_used = 0;
    seen_total = '0;
    seen_first = '0;
    seen_last = '0;
    prev_time = '0;
    flag_order = 1'b0;
    flag_dev_ovf = 1'b0;
    flag_kind_ovf = 1'b0;
  endfunction

  // fold one record into the running statistics
  function automatic void absorb_record(rsa_pkg::rsa_in_t r);
    int slot;
    logic [48:0] psum;
    if (seen_total == 0) begin
      seen_first = r.capture_time;
      seen_last = r.capture_time;
    end else begin
      if (r.capture_time < prev_time) flag_order = 1'b1;
      if (r.capture_time < seen_first) seen_first = r.capture_time;
      if (r.capture_time > seen_last) seen_last = r.capture_time;
    end
    prev_time = r.capture_time;
    seen_total = sat_add1(seen_total);

    slot = -1;
    for (int i = 0; i < dev_used; i++)
      if (dev_tab[i].id == r.device_id) begin
        slot = i;
        break;
      end
    if (slot < 0 && dev_used < NDEV) begin
      slot = dev_used++;
      dev_tab[slot] = '{id: r.device_id, cnt: '0, first: r.capture_time,
                        last: r.capture_time, pay: '0};
    end
    if (slot < 0) begin
      flag_dev_ovf = 1'b1;
    end else begin
      if (r.capture_time < dev_tab[slot].first) dev_tab[slot].first = r.capture_time;
      if (r.capture_time > dev_tab[slot].last) dev_tab[slot].last = r.capture_time;
      dev_tab[slot].cnt = sat_add1(dev_tab[slot].cnt);
      psum = {1'b0, dev_tab[slot].pay} + 49'(r.payload_len);
      dev_tab[slot].pay = psum[48] ? rsa_pkg::PAY_MAX : psum[47:0];
    end

    slot = -1;
    for (int i = 0; i < kind_used; i++)
      if (kind_tab[i].id == r.packet_kind) begin
        slot = i;
        break;
      end
    if (slot < 0 && kind_used < NKIND) begin
      slot = kind_used++;
      kind_tab[slot] = '{id: r.packet_kind, cnt: '0};
    end
    if (slot < 0) flag_kind_ovf = 1'b1;
    else kind_tab[slot].cnt = sat_add1(kind_tab[slot].cnt);
  endfunction

  // end of archive: sorted entry dump plus summary, then clear
  function automatic void emit_archive();
    rsa_pkg::rsa_dev_t  d[$];
    rsa_pkg::rsa_kind_t k[$];
    rsa_pkg::rsa_out_t  o;
    logic [63:0] dsum = 0, ksum = 0;
    logic [10:0] warn = '0;
    for (int i = 0; i < dev_used; i++) begin
      d.insert(d.size(), dev_tab[i]);
      dsum += 64'(dev_tab[i].cnt);
      if (dev_tab[i].cnt == 0) warn[rsa_pkg::W_ZERO_CNT] = 1'b1;
      if (dev_tab[i].first > dev_tab[i].last) warn[rsa_pkg::W_INV_RANGE] = 1'b1;
    end
    for (int i = 0; i < kind_used; i++) begin
      k.insert(k.size(), kind_tab[i]);
      ksum += 64'(kind_tab[i].cnt);
    end
    d.sort() with ({~item.cnt, item.id});
    k.sort() with ({~item.cnt, item.id});
    warn[rsa_pkg::W_ORDER] = flag_order;
    warn[rsa_pkg::W_HDR_COUNT] = (seen_total != hdr_count);
    warn[rsa_pkg::W_HDR_FIRST] = (seen_total != 0) && (hdr_first != seen_first);
    warn[rsa_pkg::W_HDR_LAST] = (seen_total != 0) && (hdr_last != seen_last);
    warn[rsa_pkg::W_SUM_KIND] = (dsum != ksum);
    warn[rsa_pkg::W_SUM_TOTAL] = (seen_total != 0) && (dsum != {32'd0, seen_total});
    warn[rsa_pkg::W_EMPTY] = (seen_total == 0) && (dev_used != 0 || kind_used != 0);
    warn[rsa_pkg::W_DEV_OVF] = flag_dev_ovf;
    warn[rsa_pkg::W_KIND_OVF] = flag_kind_ovf;
    foreach (d[i]) begin
      o = '{entry_type: rsa_pkg::ET_DEVICE, entry_key: d[i].id, record_total: d[i].cnt,
            first_time: d[i].first, last_time: d[i].last, payload_total: d[i].pay,
            warnings: '0, last_of_run: 1'b0};
      expected_q.insert(expected_q.size(), o);
    end
    foreach (k[i]) begin
      o = '0;
      o.entry_type = rsa_pkg::ET_KIND;
      o.entry_key = {8'd0, k[i].id};
      o.record_total = k[i].cnt;
      expected_q.insert(expected_q.size(), o);
    end
    o = '{entry_type: rsa_pkg::ET_SUMMARY, entry_key: '0, record_total: seen_total,
          first_time: seen_first, last_time: seen_last, payload_total: '0,
          warnings: warn, last_of_run: 1'b1};
    expected_q.insert(expected_q.size(), o);
    clear_stats();
  endfunction

  // output side: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    rsa_pkg::rsa_out_t want;
    if (result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", result_ch.data);
      end else begin
        want = expected_q.pop_front();
        if (result_ch.data !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, result_ch.data);
        end
      end
    end
    result_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // one register write; returns after the enable drops
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rsa_pkg::CFG_HDR_COUNT: hdr_count = val[31:0];
      rsa_pkg::CFG_HDR_FIRST: hdr_first = val;
      default: hdr_last = val;
    endcase
    @(posedge clk_i);
  endtask

  // offer one item until taken, then update the prediction
  // the block is busy right after an accept, so idling after it costs nothing
  task automatic send_item(rsa_pkg::rsa_in_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    item_ch.valid <= 1'b0;
    if (it.operation == rsa_pkg::OP_FINISH) emit_archive();
    else absorb_record(it);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic rsa_pkg::rsa_in_t make_record(logic [15:0] dev, logic [7:0] kind,
                                                   logic [63:0] t, logic [15:0] pay);
    return '{operation: rsa_pkg::OP_RECORD, device_id: dev, packet_kind: kind,
             capture_time: t, payload_len: pay};
  endfunction

  function automatic rsa_pkg::rsa_in_t make_finish();
    rsa_pkg::rsa_in_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(rsa_pkg::rsa_in_t)-1:0];
    it.operation = rsa_pkg::OP_FINISH;
    return it;
  endfunction

  // directed table; expected values typed only for the empty archive
  rsa_pkg::rsa_in_t directed[$];

  // mostly in-order records over a small id pool, some noise
  task automatic random_archive(int n, int dev_pool, int kind_pool);
    logic [63:0] t;
    logic [15:0] dv;
    t = {$urandom, $urandom} >> $urandom_range(40, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) t = {$urandom, $urandom};
      else t += 64'($urandom_range(1000));
      dv = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(dev_pool - 1));
      send_item(make_record(dv, 8'($urandom_range(kind_pool - 1)), t,
                            16'($urandom)));
    end
    send_item(make_finish());
  endtask

  initial begin
    rsa_pkg::rsa_out_t o;
    clear_stats();
    hdr_count = '0;
    hdr_first = '0;
    hdr_last = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty archive right after reset: zero summary, nothing flagged
    o = '0;
    o.entry_type = rsa_pkg::ET_SUMMARY;
    o.last_of_run = 1'b1;
    item_ch.valid <= 1'b1;
    item_ch.data <= make_finish();
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    item_ch.valid <= 1'b0;
    expected_q.insert(expected_q.size(), o);
    drain();

    // extremes of every field, out-of-order time, repeated keys
    write_reg(rsa_pkg::CFG_HDR_COUNT, 64'd6);
    write_reg(rsa_pkg::CFG_HDR_FIRST, 64'd0);
    write_reg(rsa_pkg::CFG_HDR_LAST, '1);
    directed.insert(directed.size(), make_record(16'hFFFF, 8'hFF, '1, 16'hFFFF));
    directed.insert(directed.size(), make_record(16'h0000, 8'h00, '0, 16'h0000));
    directed.insert(directed.size(),
                    make_record(16'hFFFF, 8'h00, 64'h5555_AAAA_5555_AAAA, 16'hFFFF));
    directed.insert(directed.size(),
                    make_record(16'h0000, 8'hFF, 64'hAAAA_5555_AAAA_5555, 16'h5555));
    directed.insert(directed.size(), make_record(16'h1234, 8'h55, 64'd7, 16'hAAAA));
    directed.insert(directed.size(), make_record(16'h1234, 8'hAA, 64'd7, 16'h0001));
    directed.insert(directed.size(), make_finish());
    // one device, many kinds: kind table overflows
    for (int i = 0; i < NKIND + 2; i++)
      directed.insert(directed.size(),
                      make_record(16'h0042, 8'(i * 13), 64'(100 + i), 16'(i)));
    directed.insert(directed.size(), make_finish());
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // device table overflow with header matching
    write_reg(rsa_pkg::CFG_HDR_COUNT, 64'(NDEV + 3));
    write_reg(rsa_pkg::CFG_HDR_FIRST, 64'd1000);
    write_reg(rsa_pkg::CFG_HDR_LAST, 64'(1000 + NDEV + 2));
    for (int i = 0; i < NDEV + 3; i++)
      send_item(make_record(16'(i * 977), 8'(i % 3), 64'(1000 + i), 16'hFFFF));
    send_item(make_finish());
    drain();

    // random phases with the three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 47 : 0;
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 26 : 0;
      write_reg(rsa_pkg::CFG_HDR_COUNT,
                (ph == 2) ? 64'hFFFF_FFFF : 64'($urandom_range(20)));
      write_reg(rsa_pkg::CFG_HDR_FIRST, {$urandom, $urandom});
      write_reg(rsa_pkg::CFG_HDR_LAST, (ph == 2) ? '1 : {$urandom, $urandom});
      for (int a = 0; a < 3; a++)
        random_archive($urandom_range(22, 8), $urandom_range(40, 2), $urandom_range(20, 2));
      if (ph == 1) begin
        // long receiver hold while the sender keeps offering
        fork
          begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            recv_hold = 1'b0;
          end
          begin
            random_archive(6, 3, 3);
            random_archive(6, 3, 3);
          end
        join
      end
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
